// ===== sv/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CNT_W  = 32;
    localparam int CFG_W  = 4;
    localparam int FIDX_W = 3;

    // hit, frame_index, fault_total packed and padded to whole bytes
    localparam int M_DATA_W = ((1 + FIDX_W + CNT_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    // control part of the token that walks down the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic found;
    } lrupr_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] result;
        result = (value == CNT_MAX) ? value : value + CNT_W'(1);
        return result;
    endfunction

endpackage

// ===== sv/lrupr_cell.sv =====
module lrupr_cell #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int IDX       = 0,
    parameter int IW        = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int FW        = $clog2(FRAMES + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sequence context, stable while a token walks the row as long as cfg is written only while idle
    input  logic [FW-1:0]               filled,
    input  logic [FW-1:0]               limit,
    // write-back of the committed decision
    input  logic                        wr_en,
    input  logic [IW-1:0]               wr_slot,
    input  logic [PAGE_BITS-1:0]        wr_page,
    input  logic [lrupr_pkg::CNT_W-1:0] wr_stamp,
    // token from the previous cell
    input  lrupr_pkg::lrupr_ctl_t       in_ctl,
    input  logic [PAGE_BITS-1:0]        in_page,
    input  logic [IW-1:0]               in_hit_idx,
    input  logic [lrupr_pkg::CNT_W-1:0] in_min_stamp,
    input  logic [IW-1:0]               in_min_idx,
    // token to the next cell
    output lrupr_pkg::lrupr_ctl_t       out_ctl,
    output logic [PAGE_BITS-1:0]        out_page,
    output logic [IW-1:0]               out_hit_idx,
    output logic [lrupr_pkg::CNT_W-1:0] out_min_stamp,
    output logic [IW-1:0]               out_min_idx
);
    import lrupr_pkg::*;

    localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
    localparam logic [FW-1:0] MY_FILL = FW'(IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     stamp_reg;

    lrupr_ctl_t           ctl_reg, ctl_next;
    logic [PAGE_BITS-1:0] tok_page_reg;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]     min_stamp_reg, min_stamp_next;
    logic [IW-1:0]        min_idx_reg, min_idx_next;

    logic occupied;
    logic eligible;
    logic match;
    logic take_min;

    always_comb begin
        occupied = (MY_FILL < filled);
        eligible = (MY_FILL < limit);
        // first matching frame wins
        match    = in_ctl.valid && !in_ctl.found && occupied && (page_reg == in_page);
        // strict less keeps the lower index on a tie
        take_min = eligible && ((IDX == 0) || (stamp_reg < in_min_stamp));

        ctl_next       = in_ctl;
        ctl_next.found = in_ctl.found | match;
        hit_idx_next   = match ? MY_IDX : in_hit_idx;
        min_stamp_next = take_min ? stamp_reg : in_min_stamp;
        min_idx_next   = take_min ? MY_IDX : in_min_idx;
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_slot == MY_IDX)) begin
            page_reg  <= wr_page;
            stamp_reg <= wr_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_page_reg  <= in_page;
        hit_idx_reg   <= hit_idx_next;
        min_stamp_reg <= min_stamp_next;
        min_idx_reg   <= min_idx_next;
    end

    assign out_ctl       = ctl_reg;
    assign out_page      = tok_page_reg;
    assign out_hit_idx   = hit_idx_reg;
    assign out_min_stamp = min_stamp_reg;
    assign out_min_idx   = min_idx_reg;

endmodule

// ===== sv/lru_page_replacement.sv =====
// LRU page replacement over a fully associative set of page frames.
//
// Input channel (s_*): one page reference per transfer. s_tdata carries the
// page number, s_tlast marks the final reference of a sequence.
// Result channel (m_*): one transfer per reference with hit flag, frame index
// and running fault count in m_tdata; m_tlast echoes the input's last mark.
// Configuration channel (cfg_*): frames_in_use, to be written only while idle; the block does not enforce this.
//
// A reference walks the row of FRAMES cells, one cell per cycle. Each cell
// compares its page against the reference and its use stamp against the
// running minimum. At the end of the row the token is captured, then the
// hit/fill/evict decision is taken and written back to the chosen cell
// once the output register is free. Only one reference is in flight at a
// time, since s_tready is high only while the block is idle.
// The next reference is taken as soon as the decision is committed, even if
// the result still waits in the output register.
//
// Reset clears the frame count, reference and fault counters and sets
// frames_in_use to 8. After a result marked last the same clearing happens.
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cfg_data: frames_in_use [3:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data,
    // s_tdata: page_number [PAGE_BITS-1:0], zero padded to whole bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                s_tlast,
    // m_tdata: hit [0], frame_index [3:1], fault_total [35:4], zero pad [39:36]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrupr_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import lrupr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW = $clog2(FRAMES + 1);
    localparam int PAD_W = M_DATA_W - (1 + FIDX_W + CNT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]     cfg_reg;
    logic [FW-1:0]        filled_reg;
    logic [CNT_W-1:0]     ref_cnt_reg;
    logic [CNT_W-1:0]     fault_cnt_reg;

    // token injected at the head of the row
    logic                 inj_valid_reg;
    logic                 inj_last_reg;
    logic [PAGE_BITS-1:0] inj_page_reg;

    // token captured at the tail of the row
    logic                 tok_found_reg;
    logic                 tok_last_reg;
    logic [PAGE_BITS-1:0] tok_page_reg;
    logic [IW-1:0]        tok_hit_idx_reg;
    logic [IW-1:0]        tok_min_idx_reg;

    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    // cell row links
    lrupr_ctl_t           chain_ctl       [FRAMES+1];
    logic [PAGE_BITS-1:0] chain_page      [FRAMES+1];
    logic [IW-1:0]        chain_hit_idx   [FRAMES+1];
    logic [CNT_W-1:0]     chain_min_stamp [FRAMES+1];
    logic [IW-1:0]        chain_min_idx   [FRAMES+1];

    logic [FW-1:0]        limit;
    logic                 out_free;
    logic                 commit;
    logic                 room;
    logic [IW-1:0]        slot;
    logic [FW-1:0]        filled_next;
    logic [CNT_W-1:0]     fault_next;

    // clamp frames_in_use to 1..FRAMES
    always_comb begin
        if (cfg_reg == '0) begin
            limit = FW'(1);
        end else if (int'(cfg_reg) > FRAMES) begin
            limit = FW'(FRAMES);
        end else begin
            limit = FW'(cfg_reg);
        end
    end

    // head of the row: reference from the input register, empty minimum
    // (control fields valid, last, found from the top bit down)
    assign chain_ctl[0]       = {inj_valid_reg, inj_last_reg, 1'b0};
    assign chain_page[0]      = inj_page_reg;
    assign chain_hit_idx[0]   = '0;
    assign chain_min_stamp[0] = '0;
    assign chain_min_idx[0]   = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g),
            .IW        (IW),
            .FW        (FW)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .filled        (filled_reg),
            .limit         (limit),
            .wr_en         (commit),
            .wr_slot       (slot),
            .wr_page       (tok_page_reg),
            .wr_stamp      (ref_cnt_reg),
            .in_ctl        (chain_ctl[g]),
            .in_page       (chain_page[g]),
            .in_hit_idx    (chain_hit_idx[g]),
            .in_min_stamp  (chain_min_stamp[g]),
            .in_min_idx    (chain_min_idx[g]),
            .out_ctl       (chain_ctl[g+1]),
            .out_page      (chain_page[g+1]),
            .out_hit_idx   (chain_hit_idx[g+1]),
            .out_min_stamp (chain_min_stamp[g+1]),
            .out_min_idx   (chain_min_idx[g+1])
        );
    end

    // decision: hit, fill the next empty frame, or evict the oldest
    always_comb begin
        out_free    = !m_tvalid_reg || m_tready;
        commit      = (state_reg == ST_COMMIT) && out_free;
        room        = (filled_reg < limit);
        filled_next = filled_reg;
        if (tok_found_reg) begin
            slot = tok_hit_idx_reg;
        end else if (room) begin
            slot        = IW'(filled_reg);
            filled_next = filled_reg + FW'(1);
        end else begin
            slot = tok_min_idx_reg;
        end
        fault_next = tok_found_reg ? fault_cnt_reg : sat_inc(fault_cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= CFG_RESET;
            filled_reg    <= '0;
            ref_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            inj_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            inj_valid_reg <= 1'b0;
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // take the reference and launch it down the row
                    if (s_tvalid) begin
                        inj_valid_reg <= 1'b1;
                        inj_last_reg  <= s_tlast;
                        inj_page_reg  <= s_tdata[PAGE_BITS-1:0];
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // hold the token that leaves the last cell
                    if (chain_ctl[FRAMES].valid) begin
                        tok_found_reg   <= chain_ctl[FRAMES].found;
                        tok_last_reg    <= chain_ctl[FRAMES].last;
                        tok_page_reg    <= chain_page[FRAMES];
                        tok_hit_idx_reg <= chain_hit_idx[FRAMES];
                        tok_min_idx_reg <= chain_min_idx[FRAMES];
                        state_reg       <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    // commit once the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= tok_last_reg;
                        m_tdata_reg  <= {{PAD_W{1'b0}}, fault_next, FIDX_W'(slot), tok_found_reg};
                        if (tok_last_reg) begin
                            // end of sequence: drop all frames and counts
                            filled_reg    <= '0;
                            ref_cnt_reg   <= '0;
                            fault_cnt_reg <= '0;
                        end else begin
                            filled_reg    <= filled_next;
                            ref_cnt_reg   <= sat_inc(ref_cnt_reg);
                            fault_cnt_reg <= fault_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

endmodule
